### hdl/demurrage_value_decay_assert.svh
// Assertion macros for the decay block; the controller uses them.
`ifndef DEMURRAGE_VALUE_DECAY_ASSERT_SVH
`define DEMURRAGE_VALUE_DECAY_ASSERT_SVH

// Same-cycle implication, checked on clock, held off during reset.
`define DVD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock, held off during reset.
`define DVD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/dvd_pkg.sv
// Package: decay ladder constants, controller states and command types.
`timescale 1ns / 1ps
`default_nettype none

package dvd_pkg;

   // Number of ladder rungs, one per depth bit that can decay the amount
   localparam int unsigned LADDER_STEPS = 26;
   localparam int unsigned IDX_W        = 5;

   typedef logic [IDX_W-1:0] idx_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_ACC,
      ST_FIN_MUL,
      ST_FIN_SUM,
      ST_FIN_RES,
      ST_DONE
   } ctrl_state_type;

   // Datapath operations, one per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD_IN,
      OP_SEED,
      OP_LADDER_MUL,
      OP_LADDER_ACC,
      OP_FIN_MUL,
      OP_FIN_SUM,
      OP_FIN_RES,
      OP_OUT_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      idx_type   idx;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic bit_set;
   } sts_type;

   // Rate for depth 2^i in 0.64 fixed point: {high word, low word}
   function automatic logic [63:0] ladder_rung(input idx_type idx);
      logic [63:0] rung;
      case (idx)
         5'd0:    rung = 64'hfffff000_00000000;
         5'd1:    rung = 64'hffffe000_01000000;
         5'd2:    rung = 64'hffffc000_05ffffc0;
         5'd3:    rung = 64'hffff8000_1bfffc80;
         5'd4:    rung = 64'hffff0000_77ffdd00;
         5'd5:    rung = 64'hfffe0001_effeca00;
         5'd6:    rung = 64'hfffc0007_dff5d409;
         5'd7:    rung = 64'hfff8001f_bfaca8a2;
         5'd8:    rung = 64'hfff0007f_7d5d5a6a;
         5'd9:    rung = 64'hffe001fe_eacb48a8;
         5'd10:   rung = 64'hffc007fd_55dfda2a;
         5'd11:   rung = 64'hff801ff6_ad5499cd;
         5'd12:   rung = 64'hff007fcd_67f98aad;
         5'd13:   rung = 64'hfe01fe9b_74f0943e;
         5'd14:   rung = 64'hfc07f540_767d2a82;
         5'd15:   rung = 64'hf81fab16_3dc15990;
         5'd16:   rung = 64'hf07d5f65_f9604ac9;
         5'd17:   rung = 64'he1eb5045_80b6ebf7;
         5'd18:   rung = 64'hc75f7b66_a5075def;
         5'd19:   rung = 64'h9b459576_663bbb3e;
         5'd20:   rung = 64'h5e2d55e7_48e27ab4;
         5'd21:   rung = 64'h22a5531d_29a95916;
         5'd22:   rung = 64'h04b054d7_fda49c4d;
         5'd23:   rung = 64'h0015fc1b_85085be9;
         5'd24:   rung = 64'h000001e3_54ca043c;
         5'd25:   rung = 64'h00000000_00039089;
         default: rung = 64'h0;
      endcase
      return rung;
   endfunction

endpackage

`default_nettype wire

### hdl/dvd_ctrl.sv
// Controller: walks the depth bits and sequences the shared multipliers.
`timescale 1ns / 1ps
`default_nettype none

`include "demurrage_value_decay_assert.svh"

module dvd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  dvd_pkg::sts_type sts,
   output dvd_pkg::cmd_type cmd
);

   localparam dvd_pkg::idx_type LastIdx = dvd_pkg::idx_type'(dvd_pkg::LADDER_STEPS - 1);

   dvd_pkg::ctrl_state_type state_ff, state_in;
   dvd_pkg::idx_type        idx_ff, idx_in;
   logic                    fresh_ff, fresh_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_blocked;

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = (state_ff != dvd_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;

   // Hold state, rung index and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dvd_pkg::ST_IDLE;
         idx_ff       <= '0;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Choose next state and the datapath operation
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = out_blocked;
      cmd.op       = dvd_pkg::OP_NONE;
      cmd.idx      = idx_ff;
      case (state_ff)
         dvd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = dvd_pkg::OP_LOAD_IN;
               idx_in   = '0;
               fresh_in = 1'b1;
               state_in = dvd_pkg::ST_SCAN;
            end
         end
         dvd_pkg::ST_SCAN: begin
            if (sts.bypass) begin
               state_in = dvd_pkg::ST_DONE;
            end else if (sts.bit_set && !fresh_ff) begin
               state_in = dvd_pkg::ST_MUL;
            end else begin
               if (sts.bit_set) begin
                  cmd.op   = dvd_pkg::OP_SEED;
                  fresh_in = 1'b0;
               end
               if (idx_ff == LastIdx) begin
                  state_in = dvd_pkg::ST_FIN_MUL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         dvd_pkg::ST_MUL: begin
            cmd.op   = dvd_pkg::OP_LADDER_MUL;
            state_in = dvd_pkg::ST_ACC;
         end
         dvd_pkg::ST_ACC: begin
            cmd.op = dvd_pkg::OP_LADDER_ACC;
            if (idx_ff == LastIdx) begin
               state_in = dvd_pkg::ST_FIN_MUL;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = dvd_pkg::ST_SCAN;
            end
         end
         dvd_pkg::ST_FIN_MUL: begin
            cmd.op   = dvd_pkg::OP_FIN_MUL;
            state_in = dvd_pkg::ST_FIN_SUM;
         end
         dvd_pkg::ST_FIN_SUM: begin
            cmd.op   = dvd_pkg::OP_FIN_SUM;
            state_in = dvd_pkg::ST_FIN_RES;
         end
         dvd_pkg::ST_FIN_RES: begin
            cmd.op   = dvd_pkg::OP_FIN_RES;
            state_in = dvd_pkg::ST_DONE;
         end
         dvd_pkg::ST_DONE: begin
            // Wait until the output register is free
            if (!out_blocked) begin
               cmd.op       = dvd_pkg::OP_OUT_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = dvd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dvd_pkg::ST_IDLE;
         end
      endcase
   end

   `DVD_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, state_ff != dvd_pkg::ST_IDLE, "accepted item did not start work")
   `DVD_ASSERT_NEXT(a_mul_then_acc, state_ff == dvd_pkg::ST_MUL, state_ff == dvd_pkg::ST_ACC, "ladder product not accumulated")
   `DVD_ASSERT_NEXT(a_done_waits, state_ff == dvd_pkg::ST_DONE && out_blocked, state_ff == dvd_pkg::ST_DONE, "result dropped over a held item")
   `DVD_ASSERT_NOW(a_valid_from_done, $rose(rsp_valid_ff), $past(state_ff) == dvd_pkg::ST_DONE, "result shown before work finished")

endmodule

`default_nettype wire

### hdl/dvd_dpath.sv
// Datapath: rate ladder products, final scaling and the result register.
`timescale 1ns / 1ps
`default_nettype none

module dvd_dpath (
   input  logic                clock,
   input  dvd_pkg::cmd_type    cmd,
   output dvd_pkg::sts_type    sts,
   input  logic signed [63:0]  req_amount,
   input  logic signed [31:0]  req_depth,
   output logic signed [63:0]  rsp_decayed_amount
);

   logic [63:0] amount_ff;
   logic [31:0] depth_ff;
   logic        neg_ff;
   logic [63:0] mag_ff;
   logic [31:0] hi_ff, lo_ff;
   logic [63:0] p0_ff, p1_ff, p2_ff;
   logic [33:0] sum_ff;
   logic [63:0] res_ff;
   logic [63:0] out_ff;

   logic [63:0] rung;
   logic [31:0] khi, klo, v0, v1;
   logic [31:0] a0, b0, a1, b1, a2, b2;
   logic [63:0] prod0, prod1, prod2;
   logic [64:0] pair;
   logic [64:0] step;
   logic [65:0] fsum;
   logic        pass_in, zero_out;
   logic [63:0] out_in;

   assign rung = dvd_pkg::ladder_rung(cmd.idx);
   assign khi  = rung[63:32];
   assign klo  = rung[31:0];
   assign v0   = mag_ff[31:0];
   assign v1   = mag_ff[63:32];

   // Flag the special depths and pick the current depth bit
   assign pass_in  = depth_ff[31] || (depth_ff == '0);
   assign zero_out = |depth_ff[30:dvd_pkg::LADDER_STEPS];
   assign sts.bypass  = pass_in || zero_out;
   assign sts.bit_set = depth_ff[cmd.idx];

   // Steer operands into the three 32x32 multipliers
   always_comb begin
      a0 = '0; b0 = '0;
      a1 = '0; b1 = '0;
      a2 = '0; b2 = '0;
      case (cmd.op)
         dvd_pkg::OP_LADDER_MUL: begin
            a0 = klo; b0 = hi_ff;
            a1 = khi; b1 = lo_ff;
            a2 = khi; b2 = hi_ff;
         end
         dvd_pkg::OP_FIN_MUL: begin
            a0 = lo_ff; b0 = v0;
            a1 = lo_ff; b1 = v1;
            a2 = hi_ff; b2 = v0;
         end
         dvd_pkg::OP_FIN_SUM: begin
            a0 = hi_ff; b0 = v1;
         end
         default: begin
            a0 = '0;
         end
      endcase
   end

   assign prod0 = {32'b0, a0} * {32'b0, b0};
   assign prod1 = {32'b0, a1} * {32'b0, b1};
   assign prod2 = {32'b0, a2} * {32'b0, b2};

   // Ladder step: drop the low word of the cross sum, add the high product
   assign pair = {1'b0, p0_ff} + {1'b0, p1_ff};
   assign step = {32'b0, pair[64:32]} + {1'b0, p2_ff};

   // Final scaling: cross terms plus the carry-in from the low product
   assign fsum = {34'b0, p0_ff[63:32]} + {2'b0, p1_ff} + {2'b0, p2_ff};

   // Select the delivered value and restore the sign
   always_comb begin
      if (pass_in) begin
         out_in = amount_ff;
      end else if (zero_out) begin
         out_in = '0;
      end else if (neg_ff) begin
         out_in = 64'(0) - res_ff;
      end else begin
         out_in = res_ff;
      end
   end

   // Advance the datapath registers by the current operation
   always_ff @(posedge clock) begin
      case (cmd.op)
         dvd_pkg::OP_LOAD_IN: begin
            amount_ff <= req_amount;
            depth_ff  <= req_depth;
            neg_ff    <= req_amount[63];
            mag_ff    <= req_amount[63] ? 64'(0) - req_amount : req_amount;
         end
         dvd_pkg::OP_SEED: begin
            hi_ff <= khi;
            lo_ff <= klo;
         end
         dvd_pkg::OP_LADDER_MUL, dvd_pkg::OP_FIN_MUL: begin
            p0_ff <= prod0;
            p1_ff <= prod1;
            p2_ff <= prod2;
         end
         dvd_pkg::OP_LADDER_ACC: begin
            lo_ff <= step[31:0];
            hi_ff <= step[63:32];
         end
         dvd_pkg::OP_FIN_SUM: begin
            sum_ff <= fsum[65:32];
            p0_ff  <= prod0;
         end
         dvd_pkg::OP_FIN_RES: begin
            res_ff <= {30'b0, sum_ff} + p0_ff;
         end
         dvd_pkg::OP_OUT_LOAD: begin
            out_ff <= out_in;
         end
         default: begin
            out_ff <= out_ff;
         end
      endcase
   end

   assign rsp_decayed_amount = out_ff;

endmodule

`default_nettype wire

### hdl/demurrage_value_decay.sv
// Top level: decays a signed amount by (1 - 2^-20)^depth.
//
//   channel   dir   handshake          payload
//   req       in    req_valid/stall    req_amount (s64), req_depth (s32)
//   rsp       out   rsp_valid/stall    rsp_decayed_amount (s64)
//
// Flow: the scan visits all 26 rungs; each extra set bit of depth costs a multiply
//   and an accumulate on the three shared 32x32 multipliers. The next item can be
//   taken in the same cycle that the result shows.
// Depth zero, negative or 2^26 and up: the scan goes straight to the result, skipping the ladder.
// One item is in work at a time; the next is taken while a result waits on rsp_stall.
// Reset is synchronous and clears the controller and rsp_valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module demurrage_value_decay (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [63:0] req_amount,
   input  logic signed [31:0] req_depth,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_decayed_amount
);

   dvd_pkg::cmd_type cmd;
   dvd_pkg::sts_type sts;

   dvd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dvd_dpath u_dpath (
      .clock              (clock),
      .cmd                (cmd),
      .sts                (sts),
      .req_amount         (req_amount),
      .req_depth          (req_depth),
      .rsp_decayed_amount (rsp_decayed_amount)
   );

endmodule

`default_nettype wire

### dv/decay_check.sv
// Decay checker: predicts each decayed amount and compares it with the block's result.
`timescale 1ns / 1ps

module decay_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_amount,
   input  logic [31:0] req_depth,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_decayed_amount,
   output int          pending_count,
   output int          fail_count
);

   typedef struct packed {
      logic [63:0] amount;
      logic [31:0] depth;
      logic [63:0] decayed;
   } decay_entry_type;

   decay_entry_type expected_decay_q[$];
   int fail_total = 0;
   int pending_total = 0;

   assign fail_count    = fail_total;
   assign pending_count = pending_total;

   // Rate for a depth of 2^k in unsigned 0.64 fixed point: {high word, low word}
   function automatic logic [63:0] pow2_rate(input int unsigned k);
      logic [63:0] rate;
      case (k)
         0:       rate = 64'hfffff000_00000000;
         1:       rate = 64'hffffe000_01000000;
         2:       rate = 64'hffffc000_05ffffc0;
         3:       rate = 64'hffff8000_1bfffc80;
         4:       rate = 64'hffff0000_77ffdd00;
         5:       rate = 64'hfffe0001_effeca00;
         6:       rate = 64'hfffc0007_dff5d409;
         7:       rate = 64'hfff8001f_bfaca8a2;
         8:       rate = 64'hfff0007f_7d5d5a6a;
         9:       rate = 64'hffe001fe_eacb48a8;
         10:      rate = 64'hffc007fd_55dfda2a;
         11:      rate = 64'hff801ff6_ad5499cd;
         12:      rate = 64'hff007fcd_67f98aad;
         13:      rate = 64'hfe01fe9b_74f0943e;
         14:      rate = 64'hfc07f540_767d2a82;
         15:      rate = 64'hf81fab16_3dc15990;
         16:      rate = 64'hf07d5f65_f9604ac9;
         17:      rate = 64'he1eb5045_80b6ebf7;
         18:      rate = 64'hc75f7b66_a5075def;
         19:      rate = 64'h9b459576_663bbb3e;
         20:      rate = 64'h5e2d55e7_48e27ab4;
         21:      rate = 64'h22a5531d_29a95916;
         22:      rate = 64'h04b054d7_fda49c4d;
         23:      rate = 64'h0015fc1b_85085be9;
         24:      rate = 64'h000001e3_54ca043c;
         25:      rate = 64'h00000000_00039089;
         default: rate = 64'h0;
      endcase
      return rate;
   endfunction

   // Decayed amount: build the rate from the set depth bits, then scale the magnitude
   function automatic logic [63:0] decay_amount(input logic [63:0] amount,
                                                input logic [31:0] depth);
      logic [63:0]  mag, rate, rate_hi, rate_lo, hi, lo, v0, v1, scaled;
      logic [127:0] wide;
      logic         fresh;
      mag = amount[63] ? (64'd0 - amount) : amount;
      // No decay for a zero or negative depth; nothing left past the ladder
      if (depth == 32'd0 || depth[31])
         return amount;
      if (depth[30:26] != 5'd0)
         return 64'd0;
      hi    = 64'd0;
      lo    = 64'd0;
      fresh = 1'b1;
      for (int k = 0; k < 26; k++) begin
         if (depth[k]) begin
            rate    = pow2_rate(k);
            rate_hi = {32'd0, rate[63:32]};
            rate_lo = {32'd0, rate[31:0]};
            if (fresh) begin
               hi    = rate_hi;
               lo    = rate_lo;
               fresh = 1'b0;
            end else begin
               // Truncated multiply: drop the low cross word, keep carries into the top
               wide = rate_lo * hi + rate_hi * lo;
               wide = (wide >> 32) + rate_hi * hi;
               lo   = {32'd0, wide[31:0]};
               hi   = {32'd0, wide[63:32]};
            end
         end
      end
      // Scale the magnitude, dropping anything past 64 bits
      v0     = {32'd0, mag[31:0]};
      v1     = {32'd0, mag[63:32]};
      wide   = ((lo * v0) >> 32) + lo * v1 + hi * v0;
      wide   = (wide >> 32) + hi * v1;
      scaled = wide[63:0];
      return amount[63] ? (64'd0 - scaled) : scaled;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns decay check: %s", $time, msg);
      fail_total++;
   endtask

   // Queue a prediction per accepted item, match each accepted result in order
   always @(posedge clock) begin
      decay_entry_type entry;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            entry.amount  = req_amount;
            entry.depth   = req_depth;
            entry.decayed = decay_amount(req_amount, req_depth);
            expected_decay_q = {expected_decay_q, entry};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_decay_q.size() == 0) begin
               report_mismatch($sformatf("result %h with no item pending",
                                         rsp_decayed_amount));
            end else begin
               entry = expected_decay_q.pop_front();
               if (rsp_decayed_amount !== entry.decayed)
                  report_mismatch($sformatf(
                     "amount %h depth %h: decayed_amount %h, expected %h",
                     entry.amount, entry.depth, rsp_decayed_amount, entry.decayed));
            end
         end
         pending_total <= expected_decay_q.size();
      end
   end

endmodule

### dv/tb_demurrage_value_decay.sv
// Testbench top: drives amounts and depths through the decay block and gives the verdict.
`timescale 1ns / 1ps

module tb_demurrage_value_decay;

   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int DRAIN_CYCLES     = 100;
   localparam int RANDOM_PER_PHASE = 283;

   localparam logic [63:0] AMOUNT_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] AMOUNT_MAX = 64'h7fff_ffff_ffff_ffff;
   localparam logic [31:0] DEPTH_MIN  = 32'h8000_0000;
   localparam logic [31:0] DEPTH_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] DEPTH_ALL  = 32'h03ff_ffff;
   localparam logic [31:0] DEPTH_OVER = 32'h0400_0000;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_valid  = 1'b0;
   logic               req_stall;
   logic signed [63:0] req_amount = '0;
   logic signed [31:0] req_depth  = '0;
   logic               rsp_valid;
   logic               rsp_stall  = 1'b0;
   logic signed [63:0] rsp_decayed_amount;

   int fail_count;
   int pending_count;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int quiet_cycles = 0;

   always #2 clock = ~clock;

   demurrage_value_decay u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_amount         (req_amount),
      .req_depth          (req_depth),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_decayed_amount (rsp_decayed_amount)
   );

   decay_check u_decay_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_amount         (req_amount),
      .req_depth          (req_depth),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_decayed_amount (rsp_decayed_amount),
      .pending_count      (pending_count),
      .fail_count         (fail_count)
   );

   // Stall the result channel at the current phase's rate
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // End the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Idle at random, then present one item and hold it until accepted
   task automatic push_item(input logic [63:0] amount, input logic [31:0] depth);
      bit taken;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_amount <= amount;
      req_depth  <= depth;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
   endtask

   initial begin
      logic [63:0] amount;
      logic [31:0] depth;
      int          pick;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero, extremes, negative depth, past the ladder, all rungs and single rungs
      push_item(64'd0, 32'd1);
      push_item(AMOUNT_MAX, 32'd1);
      push_item(AMOUNT_MIN, 32'd1);
      push_item(AMOUNT_MIN, 32'd0);
      push_item(64'hffff_ffff_ffff_ffff, 32'd1);
      push_item(64'd1, 32'd1);
      push_item(AMOUNT_MAX, 32'd0);
      push_item(AMOUNT_MAX, 32'hffff_ffff);
      push_item(AMOUNT_MIN, DEPTH_MIN);
      push_item(AMOUNT_MAX, DEPTH_OVER);
      push_item(AMOUNT_MIN, DEPTH_MAX);
      push_item(AMOUNT_MAX, DEPTH_ALL);
      push_item(AMOUNT_MIN, DEPTH_ALL);
      push_item(AMOUNT_MAX, 32'h0200_0000);
      push_item(AMOUNT_MIN, 32'h0010_0000);
      push_item(64'hffff_ffff_f8a4_32eb, 32'h0010_0000);
      push_item(AMOUNT_MAX, 32'h0000_0400);
      push_item(64'h0123_4567_89ab_cdef, 32'h02aa_aaaa);
      push_item(64'hfedc_ba98_7654_3210, 32'h0155_5555);
      push_item(AMOUNT_MAX, 32'h03ff_fffe);

      // Random phases: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 88; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 88; end
            default: begin idle_pct = 28; stall_pct <= 28; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Amount: full range mostly, small and extreme values too
            pick = $urandom_range(99);
            if (pick < 55) begin
               amount = {$urandom, $urandom};
            end else if (pick < 75) begin
               amount = $urandom_range(1000);
               if ($urandom_range(1)) amount = 64'd0 - amount;
            end else if (pick < 85) begin
               amount = {32'd0, $urandom};
               if ($urandom_range(1)) amount = 64'd0 - amount;
            end else begin
               case ($urandom_range(4))
                  0:       amount = AMOUNT_MIN;
                  1:       amount = AMOUNT_MAX;
                  2:       amount = 64'hffff_ffff_ffff_ffff;
                  3:       amount = 64'd0;
                  default: amount = 64'd1;
               endcase
            end
            // Depth: mostly inside the ladder, some bypass and overflow noise
            pick = $urandom_range(99);
            if (pick < 60)
               depth = $urandom & DEPTH_ALL;
            else if (pick < 72)
               depth = $urandom & $urandom & $urandom & DEPTH_ALL;
            else if (pick < 80)
               depth = $urandom_range(4096, 1);
            else if (pick < 90)
               depth = $urandom;
            else if (pick < 95)
               depth = pick[0] ? 32'd0 : ($urandom | DEPTH_MIN);
            else
               depth = $urandom_range(DEPTH_MAX, DEPTH_OVER);
            if (pick < 72 && depth == 32'd0)
               depth = 32'd1 << $urandom_range(25);
            push_item(amount, depth);
         end
      end
      req_valid <= 1'b0;

      // Let the last count settle, drain, then allow the longest item time for strays
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
